@@ rtl/bta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants for the boundary-tag first-fit allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

	localparam int ARENA_WORDS  = 1024;
	localparam int MEM_AW       = $clog2(ARENA_WORDS);
	localparam int HEADER_WORDS = 4;
	localparam int FOOTER_WORDS = 1;
	localparam int OVERHEAD     = HEADER_WORDS + FOOTER_WORDS;
	localparam int ADDR_W       = 19;
	localparam int SIZE_W       = 17;
	localparam int PTR_W        = 16;
	localparam int CNT_W        = MEM_AW + 1;
	localparam int FREE_BIT     = 31;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SIZE_W-1:0] sz_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [31:0]       word_t;

	localparam ptr_t  LINK_NULL = 16'hFFFF;
	localparam addr_t HDR_A     = addr_t'(HEADER_WORDS);
	localparam addr_t OVH_A     = addr_t'(OVERHEAD);
	localparam addr_t ARENA_A   = addr_t'(ARENA_WORDS);

	typedef enum logic [1:0] {
		CMD_INIT    = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_FREE    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [5:0] {
		S_IDLE, S_DISPATCH, S_DONE,
		S_I_W0, S_I_W1, S_I_W2,
		S_A_CHK, S_A_HDR, S_A_LNK, S_A_SPLIT, S_A_NB, S_A_NF, S_A_CUR, S_A_LINKS,
		S_U_RD, S_U_LK, S_U_PW, S_U_N, S_U_NW,
		S_P_W, S_P_RD, S_P_WR,
		S_F_HDR, S_F_FT, S_F_L, S_F_LD, S_F_R, S_F_RD,
		S_F_MR, S_F_MR2, S_F_MR3, S_F_MR4, S_F_MR5,
		S_F_ML, S_F_ML2, S_F_ML3, S_F_ML4, S_F_ML5, S_F_ML6
	} state_t;

	typedef struct packed {
		cmd_t                   cmd;
		logic [MEM_AW:0]        size_words;
		logic                   ptr_null;
		logic [MEM_AW:0]        free_offset;
	} bta_req_t;

	typedef struct packed {
		logic                   status;
		logic [MEM_AW-1:0]      payload_offset;
	} bta_res_t;

	typedef struct packed {
		logic                   en;
		logic                   we;
		logic [MEM_AW-1:0]      addr;
		word_t                  wdata;
	} mem_req_t;

endpackage
`default_nettype wire

@@ rtl/bta_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bta_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_seq
// Request sequencer: walks the free list and edits boundary tags through
// one read-or-write memory port.
// ----------------------------------------------------------------------------
module bta_seq
	import bta_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire bta_req_t req,
	output logic          idle,
	output logic          res_valid,
	input  wire logic     res_ready,
	output bta_res_t      res,
	output mem_req_t      mem_req,
	input  wire word_t    mem_rdata
);

	state_t state_q, state_d, ret_q;

	cmd_t              cmd_q;
	logic [MEM_AW:0]   req_q;
	logic              pnull_q;
	logic [MEM_AW:0]   off_q;
	logic              ready_q;
	logic [MEM_AW:0]   size_q;
	ptr_t              head_q;
	ptr_t              cur_q;
	logic [CNT_W-1:0]  iter_q;
	sz_t               bs_q, s_q, rs_q, ns_q;
	ptr_t              h_q, l_q, ub_q, pb_q, up_q, un_q;
	addr_t             r_q, er_q, eb_q;
	logic              has_l_q, has_r_q;
	logic              status_q;
	logic [MEM_AW-1:0] pay_q;
	logic              oor_q;

	logic  acc_en, acc_we;
	addr_t acc_addr;
	word_t acc_wdata;
	word_t rdata;
	sz_t   rd_size;
	logic  rd_free;
	ptr_t  rd_next, rd_prev;

	logic  init_ok, alloc_ok, free_ok;
	logic  a_fit, a_split;
	addr_t a_nb;
	sz_t   a_ns;
	logic  f_big, f_ls_ok, f_r_in, f_r_fit;
	addr_t f_r;
	sz_t   f_s_mr, f_ns;

	assign rdata   = oor_q ? '0 : mem_rdata;
	assign rd_size = rdata[SIZE_W-1:0];
	assign rd_free = rdata[FREE_BIT];
	assign rd_next = rdata[15:0];
	assign rd_prev = rdata[31:16];

	assign init_ok  = (req_q >= (MEM_AW+1)'(OVERHEAD)) && (req_q <= (MEM_AW+1)'(ARENA_WORDS));
	assign alloc_ok = ready_q && (req_q != '0);
	assign free_ok  = !pnull_q && ready_q && (off_q >= (MEM_AW+1)'(HEADER_WORDS))
		&& (addr_t'(off_q) - HDR_A < ARENA_A);

	assign a_fit   = bs_q >= sz_t'(req_q);
	assign a_split = (bs_q - sz_t'(req_q)) > sz_t'(OVERHEAD);
	assign a_nb    = addr_t'(cur_q) + addr_t'(req_q) + OVH_A;
	assign a_ns    = bs_q - sz_t'(req_q) - sz_t'(OVERHEAD);

	assign f_big   = addr_t'(h_q) + OVH_A + addr_t'(rd_size) > addr_t'(size_q);
	assign f_ls_ok = addr_t'(rd_size) + HDR_A <= addr_t'(h_q) - addr_t'(1);
	assign f_r     = addr_t'(h_q) + OVH_A + addr_t'(s_q);
	assign f_r_in  = f_r < addr_t'(size_q);
	assign f_r_fit = r_q + OVH_A + addr_t'(rd_size) <= addr_t'(size_q);
	assign f_s_mr  = s_q + sz_t'(OVERHEAD) + rs_q;
	assign f_ns    = rd_size + sz_t'(OVERHEAD) + s_q;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.payload_offset = pay_q;

	assign mem_req.en    = acc_en && (acc_addr < ARENA_A);
	assign mem_req.we    = acc_we;
	assign mem_req.addr  = acc_addr[MEM_AW-1:0];
	assign mem_req.wdata = acc_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		acc_en    = 1'b0;
		acc_we    = 1'b0;
		acc_addr  = '0;
		acc_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (cmd_q)
					CMD_INIT:  state_d = init_ok ? S_I_W0 : S_DONE;
					CMD_ALLOC: state_d = alloc_ok ? S_A_CHK : S_DONE;
					CMD_FREE: begin
						if (free_ok) begin
							acc_en   = 1'b1;
							acc_addr = addr_t'(off_q) - HDR_A;
							state_d  = S_F_HDR;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_I_W0: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = '0;
				acc_wdata = word_t'(req_q - (MEM_AW+1)'(OVERHEAD));
				acc_wdata[FREE_BIT] = 1'b1;
				state_d = S_I_W1;
			end
			S_I_W1: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(1);
				acc_wdata = '1;
				state_d = S_I_W2;
			end
			S_I_W2: begin
				acc_en = 1'b1; acc_we = 1'b1;
				acc_addr  = addr_t'(req_q) - OVH_A + HDR_A;
				acc_wdata = word_t'(req_q - (MEM_AW+1)'(OVERHEAD));
				state_d = S_DONE;
			end
			S_A_CHK: begin
				if (iter_q == CNT_W'(ARENA_WORDS) || addr_t'(cur_q) >= ARENA_A) begin
					state_d = S_DONE;
				end else begin
					acc_en = 1'b1; acc_addr = addr_t'(cur_q);
					state_d = S_A_HDR;
				end
			end
			S_A_HDR: begin
				acc_en = 1'b1; acc_addr = addr_t'(cur_q) + addr_t'(1);
				state_d = S_A_LNK;
			end
			S_A_LNK: begin
				state_d = a_fit ? S_U_RD : S_A_CHK;
			end
			S_U_RD: begin
				acc_en = 1'b1; acc_addr = addr_t'(ub_q) + addr_t'(1);
				state_d = S_U_LK;
			end
			S_U_LK: begin
				if (rd_prev != LINK_NULL) begin
					acc_en = 1'b1; acc_addr = addr_t'(rd_prev) + addr_t'(1);
					state_d = S_U_PW;
				end else begin
					state_d = S_U_N;
				end
			end
			S_U_PW: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(up_q) + addr_t'(1);
				acc_wdata = {rd_prev, un_q};
				state_d = S_U_N;
			end
			S_U_N: begin
				if (un_q != LINK_NULL) begin
					acc_en = 1'b1; acc_addr = addr_t'(un_q) + addr_t'(1);
					state_d = S_U_NW;
				end else begin
					state_d = ret_q;
				end
			end
			S_U_NW: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(un_q) + addr_t'(1);
				acc_wdata = {up_q, rd_next};
				state_d = ret_q;
			end
			S_P_W: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(pb_q) + addr_t'(1);
				acc_wdata = {LINK_NULL, head_q};
				state_d = (head_q != LINK_NULL) ? S_P_RD : ret_q;
			end
			S_P_RD: begin
				acc_en = 1'b1; acc_addr = addr_t'(head_q) + addr_t'(1);
				state_d = S_P_WR;
			end
			S_P_WR: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(head_q) + addr_t'(1);
				acc_wdata = {pb_q, rd_next};
				state_d = ret_q;
			end
			S_A_SPLIT: begin
				acc_en = 1'b1; acc_we = 1'b1;
				if (a_split) begin
					acc_addr  = addr_t'(cur_q) + HDR_A + addr_t'(req_q);
					acc_wdata = word_t'(req_q);
					state_d   = S_A_NB;
				end else begin
					acc_addr  = addr_t'(cur_q);
					acc_wdata = word_t'(bs_q);
					state_d   = S_A_LINKS;
				end
			end
			S_A_NB: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = a_nb;
				acc_wdata = word_t'(a_ns);
				acc_wdata[FREE_BIT] = 1'b1;
				state_d = S_P_W;
			end
			S_A_NF: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = a_nb + HDR_A + addr_t'(a_ns);
				acc_wdata = word_t'(a_ns);
				state_d = S_A_CUR;
			end
			S_A_CUR: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(cur_q);
				acc_wdata = word_t'(req_q);
				state_d = S_A_LINKS;
			end
			S_A_LINKS: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(cur_q) + addr_t'(1);
				acc_wdata = '1;
				state_d = S_DONE;
			end
			S_F_HDR: begin
				if (rd_free || f_big) begin
					state_d = S_DONE;
				end else begin
					acc_en = 1'b1; acc_addr = addr_t'(h_q) + HDR_A + addr_t'(rd_size);
					state_d = S_F_FT;
				end
			end
			S_F_FT: begin
				if (rd_size != s_q) begin
					state_d = S_DONE;
				end else begin
					acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(h_q);
					acc_wdata = word_t'(s_q);
					acc_wdata[FREE_BIT] = 1'b1;
					state_d = S_P_W;
				end
			end
			S_F_L: begin
				if (addr_t'(h_q) >= OVH_A) begin
					acc_en = 1'b1; acc_addr = addr_t'(h_q) - addr_t'(FOOTER_WORDS);
					state_d = S_F_LD;
				end else begin
					state_d = S_F_R;
				end
			end
			S_F_LD: state_d = S_F_R;
			S_F_R: begin
				if (f_r_in) begin
					acc_en = 1'b1; acc_addr = f_r;
					state_d = S_F_RD;
				end else begin
					state_d = S_F_MR;
				end
			end
			S_F_RD: state_d = S_F_MR;
			S_F_MR: begin
				if (has_r_q) begin
					acc_en = 1'b1; acc_addr = r_q;
					state_d = S_F_MR2;
				end else begin
					state_d = S_F_ML;
				end
			end
			S_F_MR2: state_d = rd_free ? S_U_RD : S_F_ML;
			S_F_MR3: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(h_q);
				acc_wdata = word_t'(f_s_mr);
				acc_wdata[FREE_BIT] = 1'b1;
				state_d = S_F_MR4;
			end
			S_F_MR4: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = er_q;
				acc_wdata = word_t'(s_q);
				state_d = S_F_MR5;
			end
			S_F_MR5: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = r_q;
				acc_wdata = word_t'(rs_q);
				state_d = S_F_ML;
			end
			S_F_ML: begin
				if (has_l_q) begin
					acc_en = 1'b1; acc_addr = addr_t'(l_q);
					state_d = S_F_ML2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_ML2: state_d = rd_free ? S_U_RD : S_DONE;
			S_F_ML3: begin
				acc_en = 1'b1; acc_addr = addr_t'(l_q);
				state_d = S_F_ML4;
			end
			S_F_ML4: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(l_q);
				acc_wdata = word_t'(f_ns);
				acc_wdata[FREE_BIT] = 1'b1;
				state_d = S_F_ML5;
			end
			S_F_ML5: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = eb_q;
				acc_wdata = word_t'(ns_q);
				state_d = S_F_ML6;
			end
			S_F_ML6: begin
				acc_en = 1'b1; acc_we = 1'b1; acc_addr = addr_t'(h_q);
				acc_wdata = word_t'(s_q);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// arena registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			head_q  <= LINK_NULL;
			size_q  <= '0;
		end else begin
			case (state_q)
				S_DISPATCH: begin
					if (cmd_q == CMD_INIT && init_ok) begin
						ready_q <= 1'b1;
						head_q  <= '0;
						size_q  <= req_q;
					end else if (cmd_q == CMD_RELEASE) begin
						ready_q <= 1'b0;
						head_q  <= LINK_NULL;
						size_q  <= '0;
					end
				end
				S_U_LK: begin
					if (rd_prev == LINK_NULL) head_q <= rd_next;
				end
				S_P_W: begin
					if (head_q == LINK_NULL) head_q <= pb_q;
				end
				S_P_WR: head_q <= pb_q;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		oor_q <= acc_en && !acc_we && (acc_addr >= ARENA_A);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q   <= req.cmd;
					req_q   <= req.size_words;
					pnull_q <= req.ptr_null;
					off_q   <= req.free_offset;
				end
			end
			S_DISPATCH: begin
				status_q <= !((cmd_q == CMD_INIT && init_ok) || cmd_q == CMD_RELEASE);
				pay_q    <= '0;
				cur_q    <= head_q;
				iter_q   <= '0;
				h_q      <= ptr_t'(addr_t'(off_q) - HDR_A);
			end
			S_A_HDR: bs_q <= rd_size;
			S_A_LNK: begin
				if (a_fit) begin
					ub_q  <= cur_q;
					ret_q <= S_A_SPLIT;
				end else begin
					cur_q  <= rd_next;
					iter_q <= iter_q + CNT_W'(1);
				end
			end
			S_U_LK: begin
				up_q <= rd_prev;
				un_q <= rd_next;
			end
			S_A_NB: begin
				pb_q  <= ptr_t'(a_nb);
				ret_q <= S_A_NF;
			end
			S_A_LINKS: begin
				status_q <= 1'b0;
				pay_q    <= MEM_AW'(addr_t'(cur_q) + HDR_A);
			end
			S_F_HDR: s_q <= rd_size;
			S_F_FT: begin
				pb_q    <= h_q;
				ret_q   <= S_F_L;
				eb_q    <= addr_t'(h_q) + HDR_A + addr_t'(s_q);
				has_l_q <= 1'b0;
				has_r_q <= 1'b0;
			end
			S_F_LD: begin
				has_l_q <= f_ls_ok;
				l_q     <= ptr_t'(addr_t'(h_q) - addr_t'(FOOTER_WORDS) - addr_t'(rd_size) - HDR_A);
			end
			S_F_R: r_q <= f_r;
			S_F_RD: begin
				has_r_q <= f_r_fit;
				er_q    <= r_q + HDR_A + addr_t'(rd_size);
			end
			S_F_MR2: begin
				rs_q  <= rd_size;
				ub_q  <= ptr_t'(r_q);
				ret_q <= S_F_MR3;
			end
			S_F_MR3: s_q <= f_s_mr;
			S_F_MR5: eb_q <= er_q;
			S_F_ML: begin
				if (!has_l_q) status_q <= 1'b0;
			end
			S_F_ML2: begin
				ub_q  <= h_q;
				ret_q <= S_F_ML3;
				if (!rd_free) status_q <= 1'b0;
			end
			S_F_ML4: ns_q <= f_ns;
			S_F_ML6: status_q <= 1'b0;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/boundary_tag_first_fit_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// Boundary-tag heap manager, explicit free list, first-fit search.
//
// channel  dir  tdata                                        tuser
// s_*      in   cmd[1:0] size_words[12:2] free_offset[23:13]  ptr_null
// m_*      out  payload_offset[9:0]                           status
//
// One request at a time over a single-port arena RAM (one access a cycle).
// Allocate takes the first free-list block that fits, unlinks it and splits
// off the remainder when that exceeds the block overhead; free checks the
// tags, pushes the block onto the free list and merges free neighbours.
// Reset clears the control state; arena words stay undefined until written.
// One result waits in the output register; a second one holds the sequencer
// in its done state and keeps the next request out.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator
	import bta_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // cmd, size_words, free_offset
	input  wire logic        s_tuser,  // ptr_null
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,  // payload_offset, zero pad
	output logic             m_tuser   // status
);

	bta_req_t req;
	bta_res_t res, res_q;
	mem_req_t mem_req;
	word_t    mem_rdata;
	logic     idle, start, res_valid, res_ready, m_tvalid_q;

	assign req.cmd         = cmd_t'(s_tdata[1:0]);
	assign req.size_words  = s_tdata[12:2];
	assign req.free_offset = s_tdata[23:13];
	assign req.ptr_null    = s_tuser;

	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !m_tvalid_q || m_tready;

	bta_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	bta_ram #(
		.DEPTH (ARENA_WORDS),
		.WIDTH (32)
	) u_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(res_q.payload_offset);
	assign m_tuser  = res_q.status;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 16'd0)
		else $error("failed request carries a payload offset");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_offset_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata != 16'd0 |-> m_tdata >= 16'(HEADER_WORDS))
		else $error("payload offset inside a header");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request stream check for the boundary-tag first-fit allocator.
// Directed rows, then random init/allocate/free/release traffic. Every
// response is compared with an in-bench heap model kept on the request side.
// ----------------------------------------------------------------------------
module tb;
	import bta_pkg::*;

	localparam int ARENA_N    = 1024;
	localparam int HDR_N      = 4;
	localparam int FTR_N      = 1;
	localparam int OVH_N      = HDR_N + FTR_N;
	localparam int NULL_LINK  = 'hFFFF;
	localparam int LIMIT      = 10000000;
	localparam int N_RANDOM   = 800;

	typedef struct {
		cmd_t        op;
		logic [10:0] size;
		logic        pnull;
		logic [10:0] offset;
		logic        fixed;
		logic        exp_status;
		logic [9:0]  exp_offset;
	} row_t;

	typedef struct {
		logic       status;
		logic [9:0] offset;
	} resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;

	logic [31:0] heap [ARENA_N];
	bit          written [ARENA_N];
	logic [31:0] heap_sv [ARENA_N];
	bit          written_sv [ARENA_N];
	bit          probe_miss;
	int unsigned head_blk;
	int unsigned heap_size;
	bit          heap_ready;

	resp_t       resp_q[$];
	int unsigned live_q[$];
	int          errors;
	int          cycles;

	boundary_tag_first_fit_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rd(int unsigned a);
		if (a >= ARENA_N) return 32'd0;
		if (!written[a]) probe_miss = 1'b1;
		return heap[a];
	endfunction

	function automatic void wr(int unsigned a, logic [31:0] v);
		if (a < ARENA_N) begin
			heap[a] = v;
			written[a] = 1'b1;
		end
	endfunction

	function automatic int unsigned bsize(int unsigned h);
		return rd(h) & 32'h1FFFF;
	endfunction

	function automatic bit bfree(int unsigned h);
		logic [31:0] w;
		w = rd(h);
		return w[31];
	endfunction

	function automatic void bset(int unsigned h, int unsigned s, bit fr);
		wr(h, {fr, 14'd0, s[16:0]});
	endfunction

	function automatic int unsigned nxt(int unsigned h);
		return rd(h + 1) & 32'hFFFF;
	endfunction

	function automatic int unsigned prv(int unsigned h);
		return (rd(h + 1) >> 16) & 32'hFFFF;
	endfunction

	function automatic void links(int unsigned h, int unsigned n, int unsigned p);
		wr(h + 1, {p[15:0], n[15:0]});
	endfunction

	function automatic void unlink(int unsigned b);
		int unsigned p, n;
		p = prv(b);
		n = nxt(b);
		if (p != NULL_LINK) links(p, n, prv(p));
		else head_blk = n;
		if (n != NULL_LINK) links(n, nxt(n), p);
	endfunction

	function automatic void push(int unsigned b);
		links(b, head_blk, NULL_LINK);
		if (head_blk != NULL_LINK) links(head_blk, nxt(head_blk), b);
		head_blk = b;
	endfunction

	function automatic resp_t heap_alloc(int unsigned req);
		resp_t       r;
		int unsigned cur, bs, nb, ns;
		r.status = 1'b1;
		r.offset = '0;
		cur = head_blk;
		if (!heap_ready || req == 0) return r;
		for (int it = 0; it < ARENA_N && cur < ARENA_N; it++) begin
			bs = bsize(cur);
			if (bs >= req) begin
				unlink(cur);
				if (bs - req > OVH_N) begin
					nb = cur + HDR_N + req + FTR_N;
					ns = bs - OVH_N - req;
					wr(cur + HDR_N + req, req);
					bset(nb, ns, 1'b1);
					push(nb);
					wr(nb + HDR_N + ns, ns);
					bset(cur, req, 1'b0);
				end else begin
					bset(cur, bs, 1'b0);
				end
				links(cur, NULL_LINK, NULL_LINK);
				r.status = 1'b0;
				r.offset = 10'(cur + HDR_N);
				return r;
			end
			cur = nxt(cur);
		end
		return r;
	endfunction

	function automatic bit heap_free(int unsigned p);
		int unsigned h, s, eb, l, r, er, lf, ls, rs, ns;
		bit          has_l, has_r;
		has_l = 0;
		has_r = 0;
		l = 0;
		er = 0;
		if (!heap_ready || p < HDR_N) return 1'b1;
		h = p - HDR_N;
		if (h >= ARENA_N || bfree(h)) return 1'b1;
		s = bsize(h);
		if (h + HDR_N + s + FTR_N > heap_size) return 1'b1;
		if ((rd(h + HDR_N + s) & 32'h1FFFF) != s) return 1'b1;
		bset(h, s, 1'b1);
		push(h);
		eb = h + HDR_N + s;
		if (h >= OVH_N) begin
			lf = h - FTR_N;
			ls = rd(lf) & 32'h1FFFF;
			if (ls + HDR_N <= lf) begin
				l = lf - ls - HDR_N;
				has_l = 1;
			end
		end
		r = eb + FTR_N;
		if (r < heap_size) begin
			rs = bsize(r);
			if (r + HDR_N + rs + FTR_N <= heap_size) begin
				er = r + HDR_N + rs;
				has_r = 1;
			end
		end
		if (has_r && bfree(r)) begin
			rs = bsize(r);
			unlink(r);
			s = (s + OVH_N + rs) & 32'h1FFFF;
			bset(h, s, 1'b1);
			wr(er, s);
			bset(r, rs, 1'b0);
			eb = er;
		end
		if (has_l && bfree(l)) begin
			unlink(h);
			ns = (bsize(l) + OVH_N + s) & 32'h1FFFF;
			bset(l, ns, 1'b1);
			wr(eb, ns);
			bset(h, s, 1'b0);
		end
		return 1'b0;
	endfunction

	function automatic resp_t heap_step(cmd_t op, int unsigned sz, bit pn, int unsigned off);
		resp_t r;
		r.status = 1'b1;
		r.offset = '0;
		case (op)
			CMD_INIT: begin
				if (sz >= OVH_N && sz <= ARENA_N) begin
					heap_size = sz;
					heap_ready = 1;
					head_blk = 0;
					bset(0, sz - OVH_N, 1'b1);
					links(0, NULL_LINK, NULL_LINK);
					wr(HDR_N + sz - OVH_N, sz - OVH_N);
					r.status = 1'b0;
					live_q.delete();
				end
			end
			CMD_ALLOC: begin
				r = heap_alloc(sz);
				if (r.status == 1'b0) live_q.push_back(32'(r.offset));
			end
			CMD_FREE: r.status = pn ? 1'b1 : heap_free(off);
			default: begin
				heap_ready = 0;
				head_blk = NULL_LINK;
				heap_size = 0;
				r.status = 1'b0;
				live_q.delete();
			end
		endcase
		return r;
	endfunction

	// Trial free, undone from a saved copy: true when it reads no unwritten arena word.
	function automatic bit offset_safe(int unsigned off);
		int unsigned hb, hs;
		bit          hr;
		hb = head_blk;
		hs = heap_size;
		hr = heap_ready;
		heap_sv = heap;
		written_sv = written;
		probe_miss = 1'b0;
		void'(heap_free(off));
		heap = heap_sv;
		written = written_sv;
		head_blk = hb;
		heap_size = hs;
		heap_ready = hr;
		return !probe_miss;
	endfunction

	task automatic send(cmd_t op, logic [10:0] sz, logic pn, logic [10:0] off,
			bit fixed, logic es, logic [9:0] eo);
		resp_t r;
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {off, sz, op};
		s_tuser  <= pn;
		do @(posedge clk); while (!s_tready);
		r = heap_step(op, 32'(sz), pn, 32'(off));
		if (fixed && (r.status !== es || r.offset !== eo)) begin
			$display("%0t table/model disagree: expected %0b/%0d, model %0b/%0d",
				$time, es, eo, r.status, r.offset);
			errors++;
		end
		resp_q.push_back(r);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (resp_q.size() == 0) begin
				$display("%0t unexpected response: status %0b offset %0d",
					$time, m_tuser, m_tdata[9:0]);
				errors++;
			end else begin
				if (m_tuser !== resp_q[0].status) begin
					$display("%0t status: expected %0b, actual %0b",
						$time, resp_q[0].status, m_tuser);
					errors++;
				end
				if (m_tdata[9:0] !== resp_q[0].offset) begin
					$display("%0t payload_offset: expected %0d, actual %0d",
						$time, resp_q[0].offset, m_tdata[9:0]);
					errors++;
				end
				void'(resp_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (m_tready) m_tready <= $urandom_range(0, 4) != 0;
		else m_tready <= $urandom_range(0, 2) == 0 || $urandom_range(0, 30) == 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	row_t rows[$];

	function automatic void add(cmd_t op, int sz, bit pn, int off, bit fixed = 0,
			bit es = 0, int eo = 0);
		row_t r;
		r.op = op;
		r.size = 11'(sz);
		r.pnull = pn;
		r.offset = 11'(off);
		r.fixed = fixed;
		r.exp_status = es;
		r.exp_offset = 10'(eo);
		rows.push_back(r);
	endfunction

	initial begin
		int unsigned k, off, sz;
		cmd_t        op;
		bit          pn;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		cycles = 0;
		probe_miss = 1'b0;
		head_blk = NULL_LINK;
		heap_size = 0;
		heap_ready = 0;
		foreach (heap[i]) begin
			heap[i] = '0;
			written[i] = 0;
		end
		// no arena yet
		add(CMD_ALLOC, 4, 0, 0, 1, 1, 0);
		add(CMD_FREE, 0, 0, 4, 1, 1, 0);
		add(CMD_INIT, 4, 0, 0, 1, 1, 0);
		add(CMD_INIT, 1025, 0, 0, 1, 1, 0);
		add(CMD_INIT, 2047, 1, 2047, 1, 1, 0);
		add(CMD_INIT, 5, 0, 0, 1, 0, 0);
		add(CMD_ALLOC, 1, 0, 0, 1, 1, 0);
		add(CMD_INIT, 1024, 0, 0, 1, 0, 0);
		add(CMD_ALLOC, 0, 0, 0, 1, 1, 0);
		add(CMD_ALLOC, 2047, 0, 0, 1, 1, 0);
		add(CMD_ALLOC, 10, 0, 0, 1, 0, 4);
		add(CMD_ALLOC, 20, 0, 0, 1, 0, 19);
		add(CMD_ALLOC, 3, 0, 0);
		add(CMD_FREE, 0, 1, 4, 1, 1, 0);
		add(CMD_FREE, 0, 0, 3, 1, 1, 0);
		add(CMD_FREE, 0, 0, 19);
		add(CMD_FREE, 0, 0, 19, 1, 1, 0);
		add(CMD_FREE, 0, 0, 4);
		add(CMD_ALLOC, 1000, 0, 0);
		add(CMD_FREE, 0, 0, 2047);
		add(CMD_RELEASE, 2047, 1, 2047, 1, 0, 0);
		add(CMD_FREE, 0, 0, 4, 1, 1, 0);
		add(CMD_INIT, 12, 0, 0, 1, 0, 0);
		add(CMD_ALLOC, 7, 0, 0, 1, 0, 4);
		add(CMD_ALLOC, 1, 0, 0, 1, 1, 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].op, rows[i].size, rows[i].pnull, rows[i].offset,
				rows[i].fixed, rows[i].exp_status, rows[i].exp_offset);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				s_tvalid <= 1'b0;
				while (resp_q.size() != 0) @(posedge clk);
				repeat (60) @(posedge clk);
			end
			k = $urandom_range(0, 99);
			pn = 0;
			off = 0;
			sz = 0;
			if (!heap_ready || k < 2) begin
				op = CMD_INIT;
				sz = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) :
					$urandom_range(0, 3) == 0 ? 1024 : $urandom_range(5, 400);
			end else if (k < 4) begin
				op = CMD_RELEASE;
				sz = $urandom_range(0, 2047);
				off = $urandom_range(0, 2047);
				pn = $urandom_range(0, 1);
			end else if (k < 52) begin
				op = CMD_ALLOC;
				sz = $urandom_range(0, 19) == 0 ? $urandom_range(0, 2047) :
					$urandom_range(1, 40);
			end else begin
				op = CMD_FREE;
				k = $urandom_range(0, 9);
				if (k < 7 && live_q.size() != 0) begin
					k = $urandom_range(0, live_q.size() - 1);
					off = live_q[k];
					live_q.delete(k);
				end else if (k == 7) begin
					pn = 1;
					off = $urandom_range(0, 2047);
				end else begin
					off = $urandom_range(0, 2047);
				end
				if (!pn && !offset_safe(off))
					off = $urandom_range(0, 1) ? 2047 : 1024 + HDR_N;
			end
			send(op, 11'(sz), pn, 11'(off), 0, 0, 0);
		end
		s_tvalid <= 1'b0;
		while (resp_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
